// ===== hdl/idal_pkg.sv =====
// idal_pkg: shared constants, request codes and sequencer states for the id allow-list table
// no dependencies
`timescale 1ns / 1ps

package idal_pkg;

	localparam int TABLE_DEPTH = 20;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int REQ_W = 2;
	localparam int ID_W = 16;
	localparam int COUNT_W = 5;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOVE,
		ST_RESP
	} state_t;

endpackage

// ===== hdl/idal_req_if.sv =====
// idal_req_if: request channel, valid/ready with request kind and id
// depends on idal_pkg
`timescale 1ns / 1ps

interface idal_req_if;
	logic                         valid;
	logic                         ready;
	logic [idal_pkg::REQ_W-1:0]   req_type;
	logic [idal_pkg::ID_W-1:0]    id;

	modport source (output valid, output req_type, output id, input ready);
	modport sink (input valid, input req_type, input id, output ready);
endinterface

// ===== hdl/idal_rsp_if.sv =====
// idal_rsp_if: response channel, valid/ready with success flag and count
// depends on idal_pkg
`timescale 1ns / 1ps

interface idal_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          success;
	logic [idal_pkg::COUNT_W-1:0]  count;

	modport source (output valid, output success, output count, input ready);
	modport sink (input valid, input success, input count, output ready);
endinterface

// ===== hdl/id_allow_list_table_core.sv =====
// id_allow_list_table_core: packed allow-list of ids with add, swap-remove and look up
// a miss scans every stored entry before the response; a hit stops the scan at its slot, and a
// remove that hits adds the ST_MOVE step before ST_RESP.
// one request at a time, the next beat is taken the cycle after the response beat; the scan
// is linear, one entry read per cycle.
// reset clears the count and the sequencer; table contents are not cleared. deps: idal_pkg, ifs
`timescale 1ns / 1ps

module id_allow_list_table_core (
	input  logic        clk,
	input  logic        arst_n,
	idal_req_if.sink    req,
	idal_rsp_if.source  rsp
);
	import idal_pkg::*;

	state_t state_q, state_d;

	logic [REQ_W-1:0] req_type_q;
	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic [CNT_W-1:0] count_q;
	logic             cmp_valid_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic             success_q;

	logic [ID_W-1:0]  mem [TABLE_DEPTH];
	logic [ID_W-1:0]  rd_data_q;

	logic             mem_rd_en;
	logic [IDX_W-1:0] mem_rd_addr;
	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	logic [ID_W-1:0]  mem_wr_data;
	logic             scan_rd;

	logic             hit;
	logic             scan_more;
	logic             scan_done;
	logic             add_ok;
	logic             req_ok;
	logic [CNT_W-1:0] cnt_dec;

	assign hit       = cmp_valid_s1 && (rd_data_q == id_q);
	assign scan_more = scan_idx_q < count_q;
	assign scan_done = hit || (!cmp_valid_s1 && !scan_more);
	assign add_ok    = (count_q < DEPTH_CNT) && (id_q != '0) && !found_q;
	assign cnt_dec   = count_q - CNT_W'(1);

	always_comb begin
		case (req_type_q)
			REQ_ADD:    req_ok = add_ok;
			REQ_REMOVE: req_ok = found_q;
			REQ_LOOKUP: req_ok = found_q;
			default:    req_ok = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (req_type_q == REQ_REMOVE && found_q) state_d = ST_MOVE;
				else state_d = ST_RESP;
			end
			ST_MOVE: state_d = ST_RESP;
			ST_RESP: begin
				if (rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		req.ready   = 1'b0;
		rsp.valid   = 1'b0;
		scan_rd     = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = scan_idx_q[IDX_W-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = count_q[IDX_W-1:0];
		mem_wr_data = id_q;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: begin
				scan_rd   = scan_more && !hit;
				mem_rd_en = scan_rd;
			end
			ST_DECIDE: begin
				if (req_type_q == REQ_ADD && add_ok) begin
					mem_wr_en = 1'b1;
				end
				if (req_type_q == REQ_REMOVE && found_q) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = cnt_dec[IDX_W-1:0];
				end
			end
			ST_MOVE: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = found_idx_q;
				mem_wr_data = rd_data_q;
			end
			ST_RESP: rsp.valid = 1'b1;
			default: ;
		endcase
	end

	assign rsp.success = success_q;
	assign rsp.count   = COUNT_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			cmp_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
			scan_idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						scan_idx_q <= '0;
						found_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					cmp_valid_s1 <= scan_rd;
					if (scan_rd) scan_idx_q <= scan_idx_q + CNT_W'(1);
					if (hit) found_q <= 1'b1;
				end
				ST_DECIDE: begin
					cmp_valid_s1 <= 1'b0;
					if (req_type_q == REQ_ADD && add_ok) count_q <= count_q + CNT_W'(1);
				end
				ST_MOVE: count_q <= cnt_dec;
				default: cmp_valid_s1 <= 1'b0;
			endcase
		end
	end

	// beat payload and scan bookkeeping
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			req_type_q <= req.req_type;
			id_q       <= req.id;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_s1 <= scan_idx_q[IDX_W-1:0];
			if (hit) found_idx_q <= cmp_idx_s1;
		end
		if (state_q == ST_DECIDE) success_q <= req_ok;
	end

	// table memory
	always_ff @(posedge clk) begin
		if (mem_wr_en) mem[mem_wr_addr] <= mem_wr_data;
		if (mem_rd_en) rd_data_q <= mem[mem_rd_addr];
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count above table depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DECIDE && state_q != ST_MOVE) |=> $stable(count_q))
		else $error("count changed outside update states");

	a_move_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOVE |-> (found_q && req_type_q == REQ_REMOVE && count_q != '0))
		else $error("move without a hit on remove");

	a_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid_s1 |-> (CNT_W'(cmp_idx_s1) < count_q))
		else $error("compare beyond stored entries");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while response pending");
`endif

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for id_allow_list_table_core, directed table then random requests
// predicts success and count from its id table copy or a typed row; checks each response beat
// depends on idal_pkg, idal_req_if, idal_rsp_if and id_allow_list_table_core
`timescale 1ns / 1ps

module tb_top;
	import idal_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int POOL_SIZE = 24;
	localparam int PHASE_ITEMS = 250;
	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int N_ROWS = 13;

	typedef struct packed {
		logic               success;
		logic [COUNT_W-1:0] count;
	} table_rsp_t;

	typedef struct {
		logic [REQ_W-1:0]   kind;
		logic [ID_W-1:0]    key;
		int                 reps;
		bit                 typed;
		logic               exp_ok;
		logic [COUNT_W-1:0] exp_count;
	} directed_row_t;

	// rows with reps > 1 step the id by one per beat
	directed_row_t directed_rows [N_ROWS] = '{
		'{REQ_LOOKUP, 16'h0000, 1, 1'b1, 1'b0, 5'd0},
		'{REQ_ADD, 16'h0000, 1, 1'b1, 1'b0, 5'd0},
		'{REQ_UNUSED, 16'hFFFF, 1, 1'b1, 1'b0, 5'd0},
		'{REQ_ADD, 16'hFFFF, 1, 1'b1, 1'b1, 5'd1},
		'{REQ_ADD, 16'hFFFF, 1, 1'b1, 1'b0, 5'd1},
		'{REQ_REMOVE, 16'hFFFF, 1, 1'b1, 1'b1, 5'd0},
		'{REQ_ADD, 16'h8001, 20, 1'b0, 1'b0, 5'd0},
		'{REQ_ADD, 16'h7FFF, 1, 1'b1, 1'b0, 5'd20},
		'{REQ_REMOVE, 16'h8005, 1, 1'b1, 1'b1, 5'd19},
		'{REQ_LOOKUP, 16'h8014, 1, 1'b1, 1'b1, 5'd19},
		'{REQ_REMOVE, 16'h8013, 1, 1'b1, 1'b1, 5'd18},
		'{REQ_LOOKUP, 16'h8005, 1, 1'b1, 1'b0, 5'd18},
		'{REQ_UNUSED, 16'h0000, 1, 1'b1, 1'b0, 5'd18}
	};

	logic clk;
	logic arst_n;

	idal_req_if req_if();
	idal_rsp_if rsp_if();

	id_allow_list_table_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	logic [ID_W-1:0] model_ids [TABLE_DEPTH];
	int              model_count = 0;
	table_rsp_t      pending_rsp [$];
	int              mismatch_count = 0;
	int              src_idle_pct = 6;
	int              snk_idle_pct = 70;
	int              hold_asked = 0;
	logic [ID_W-1:0] id_pool [POOL_SIZE];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic table_rsp_t predict_table(input logic [REQ_W-1:0] kind,
		input logic [ID_W-1:0] key);
		table_rsp_t r;
		int hit;
		hit = -1;
		for (int s = 0; s < model_count; s++) begin
			if (hit < 0 && model_ids[s] == key) hit = s;
		end
		r.success = 1'b0;
		case (kind)
			REQ_ADD: begin
				if (model_count < TABLE_DEPTH && key != '0 && hit < 0) begin
					model_ids[model_count] = key;
					model_count++;
					r.success = 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (hit >= 0) begin
					model_count--;
					model_ids[hit] = model_ids[model_count];
					r.success = 1'b1;
				end
			end
			REQ_LOOKUP: begin
				r.success = (hit >= 0);
			end
			default: begin
			end
		endcase
		r.count = COUNT_W'(model_count);
		return r;
	endfunction

	task automatic offer_request(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] key,
		input bit typed, input table_rsp_t typed_rsp);
		table_rsp_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= kind;
		req_if.id <= key;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		predicted = predict_table(kind, key);
		pending_rsp.push_back(typed ? typed_rsp : predicted);
	endtask

	// response side: ready pattern, long hold on request, beat checking
	initial begin
		int hold_left;
		int hold_served;
		table_rsp_t exp_rsp;
		hold_left = 0;
		hold_served = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_rsp.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected response beat: success %b count %0d",
							rsp_if.success, rsp_if.count);
				end else begin
					exp_rsp = pending_rsp.pop_front();
					if (rsp_if.success !== exp_rsp.success || rsp_if.count !== exp_rsp.count) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected success %b count %0d, got success %b count %0d",
								exp_rsp.success, exp_rsp.count, rsp_if.success, rsp_if.count);
					end
				end
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_served != hold_asked) begin
				hold_served++;
				hold_left = LONG_HOLD;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [REQ_W-1:0] kind;
		logic [ID_W-1:0] key;
		int draw;
		int tilt;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_ADD;
		req_if.id <= '0;
		tilt = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = ID_W'($urandom_range(65535, 1));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			for (int k = 0; k < directed_rows[r].reps; k++)
				offer_request(directed_rows[r].kind, directed_rows[r].key + ID_W'(k),
					directed_rows[r].typed,
					table_rsp_t'{directed_rows[r].exp_ok, directed_rows[r].exp_count});
		end

		for (int phase = 0; phase < 3; phase++) begin
			// sender pause until the table has answered everything
			req_if.valid <= 1'b0;
			do @(posedge clk); while (pending_rsp.size() != 0);
			case (phase)
				0: begin
					src_idle_pct = 6;
					snk_idle_pct = 70;
				end
				1: begin
					src_idle_pct = 70;
					snk_idle_pct = 6;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
					hold_asked <= hold_asked + 1;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stretches that lean toward filling, draining or neither
				if (n % 40 == 0) tilt = $urandom_range(2);
				draw = $urandom_range(99);
				if (draw < (tilt == 0 ? 55 : tilt == 1 ? 20 : 35))
					kind = REQ_ADD;
				else if (draw < (tilt == 0 ? 70 : 65))
					kind = REQ_REMOVE;
				else if (draw < 95)
					kind = REQ_LOOKUP;
				else
					kind = REQ_UNUSED;
				draw = $urandom_range(99);
				if (draw < 80)
					key = id_pool[$urandom_range(POOL_SIZE - 1)];
				else if (draw < 88)
					key = '0;
				else
					key = ID_W'($urandom);
				if ($urandom_range(99) < 4)
					id_pool[$urandom_range(POOL_SIZE - 1)] = ID_W'($urandom_range(65535, 1));
				offer_request(kind, key, 1'b0, '0);
			end
		end

		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
